### hw/rtl/mec_pkg.sv
// shared constants, types and command/status words for the mandelbrot escape colorer
package mec_pkg;

    localparam int MAX_ITER      = 255;
    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 600;

    localparam int FRAC      = 28;
    localparam int PIX_W     = 10;
    localparam int C_W       = 32;
    localparam int STEP_W    = 31;
    localparam int OFS_W     = PIX_W + 2;
    localparam int MAP_W     = OFS_W + C_W;
    localparam int Z_W       = 34;
    localparam int MUL_W     = 31;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int CNT_W     = $clog2(MAX_ITER + 1);
    localparam int REM_W     = $clog2(MAX_ITER);
    localparam int CH_W      = 8;
    localparam int NUM_W     = REM_W + CH_W;
    localparam int RECIP_SH  = NUM_W + REM_W;
    localparam int RECIP_W   = NUM_W + 2;
    localparam int PQ_W      = NUM_W + RECIP_W;
    localparam int SX_W      = 3;
    localparam int HUE_STEP  = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [OFS_W-1:0] HALF_COL = OFS_W'(SCREEN_WIDTH / 2);
    localparam logic signed [OFS_W-1:0] HALF_ROW = OFS_W'(SCREEN_HEIGHT / 2);

    localparam logic signed [Z_W-1:0]    TWO_POS   = Z_W'(1) << (FRAC + 1);
    localparam logic signed [Z_W-1:0]    TWO_NEG   = -TWO_POS;
    localparam logic signed [PROD_W:0]   FOUR_Q56  = (PROD_W + 1)'(1) << (2 * FRAC + 2);
    localparam logic [CH_W-1:0]          CHAN_MAX  = {CH_W{1'b1}};

    // ceiling of 2^RECIP_SH over the iteration limit
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << RECIP_SH) + longint'(MAX_ITER) - 1) / longint'(MAX_ITER));

    localparam logic [STEP_W-1:0] RST_PIXEL_STEP  = STEP_W'(1342177);
    localparam logic signed [C_W-1:0] RST_CENTER_REAL = -C_W'(187904819);
    localparam logic signed [C_W-1:0] RST_CENTER_IMAG = '0;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_REAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_IMAG = 2'd2;

    localparam logic [SX_W-1:0] SX_RED     = 3'd0;
    localparam logic [SX_W-1:0] SX_YELLOW  = 3'd1;
    localparam logic [SX_W-1:0] SX_GREEN   = 3'd2;
    localparam logic [SX_W-1:0] SX_CYAN    = 3'd3;
    localparam logic [SX_W-1:0] SX_BLUE    = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_CHK,
        ST_UPD,
        ST_FIN,
        ST_DIV,
        ST_OUT
    } mec_state_t;

    typedef struct packed {
        logic load;
        logic map;
        logic mul;
        logic upd;
        logic div_init;
        logic div_step;
        logic out_load;
    } mec_cmd_t;

    typedef struct packed {
        logic esc_mag;
        logic esc_sum;
        logic last_iter;
    } mec_sts_t;

endpackage

### hw/rtl/mec_ctrl.sv
// controller state machine sequencing mapping, iterations, color divide and output
module mec_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  mec_pkg::mec_sts_t sts,
    output mec_pkg::mec_cmd_t cmd
);

    mec_pkg::mec_state_t state_reg;
    mec_pkg::mec_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != mec_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mec_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            mec_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = mec_pkg::ST_MAP;
                end
            end
            mec_pkg::ST_MAP:
            begin
                cmd.map    = 1'b1;
                state_next = mec_pkg::ST_CHK;
            end
            mec_pkg::ST_CHK:
            begin
                cmd.mul = 1'b1;
                if (sts.esc_mag)
                begin
                    state_next = mec_pkg::ST_FIN;
                end
                else
                begin
                    state_next = mec_pkg::ST_UPD;
                end
            end
            mec_pkg::ST_UPD:
            begin
                if (sts.esc_sum)
                begin
                    state_next = mec_pkg::ST_FIN;
                end
                else
                begin
                    cmd.upd = 1'b1;
                    if (sts.last_iter)
                    begin
                        state_next = mec_pkg::ST_FIN;
                    end
                    else
                    begin
                        state_next = mec_pkg::ST_CHK;
                    end
                end
            end
            mec_pkg::ST_FIN:
            begin
                cmd.div_init = 1'b1;
                state_next   = mec_pkg::ST_DIV;
            end
            mec_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = mec_pkg::ST_OUT;
            end
            mec_pkg::ST_OUT:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = mec_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mec_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

endmodule

### hw/rtl/mec_dpath.sv
// datapath: config registers, pixel mapping, z iteration, hue divide and output word
module mec_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mec_pkg::C_W-1:0]       cfg_data,
    input  logic [mec_pkg::PIX_W-1:0]     pixel_col,
    input  logic [mec_pkg::PIX_W-1:0]     pixel_row,
    input  mec_pkg::mec_cmd_t             cmd,
    output mec_pkg::mec_sts_t             sts,
    output logic [mec_pkg::CH_W-1:0]      escape_count,
    output logic [mec_pkg::CH_W-1:0]      red,
    output logic [mec_pkg::CH_W-1:0]      green,
    output logic [mec_pkg::CH_W-1:0]      blue
);

    localparam int SUM_W = mec_pkg::MAP_W + 1;
    localparam int CNTX_W = mec_pkg::CNT_W + mec_pkg::CH_W;
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(32'h7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);

    // configuration
    logic [mec_pkg::STEP_W-1:0]        step_reg;
    logic signed [mec_pkg::C_W-1:0]    cen_re_reg;
    logic signed [mec_pkg::C_W-1:0]    cen_im_reg;

    // mapping
    logic signed [mec_pkg::OFS_W-1:0]  dc;
    logic signed [mec_pkg::OFS_W-1:0]  dr;
    logic signed [mec_pkg::C_W-1:0]    step_s;
    logic signed [mec_pkg::MAP_W-1:0]  map_re_reg;
    logic signed [mec_pkg::MAP_W-1:0]  map_im_reg;
    logic signed [SUM_W-1:0]           sum_re;
    logic signed [SUM_W-1:0]           sum_im;
    logic signed [mec_pkg::C_W-1:0]    sat_re;
    logic signed [mec_pkg::C_W-1:0]    sat_im;

    // iteration
    logic signed [mec_pkg::C_W-1:0]    cr_reg;
    logic signed [mec_pkg::C_W-1:0]    ci_reg;
    logic signed [mec_pkg::Z_W-1:0]    x_reg;
    logic signed [mec_pkg::Z_W-1:0]    y_reg;
    logic signed [mec_pkg::MUL_W-1:0]  mx;
    logic signed [mec_pkg::MUL_W-1:0]  my;
    logic signed [mec_pkg::PROD_W-1:0] p_xx_reg;
    logic signed [mec_pkg::PROD_W-1:0] p_yy_reg;
    logic signed [mec_pkg::PROD_W-1:0] p_xy_reg;
    logic signed [mec_pkg::PROD_W:0]   sum_sq;
    logic signed [mec_pkg::PROD_W:0]   diff_sq;
    logic signed [mec_pkg::Z_W-1:0]    x_new;
    logic signed [mec_pkg::Z_W-1:0]    y_new;
    logic [mec_pkg::CNT_W-1:0]         cnt_reg;
    logic [mec_pkg::REM_W-1:0]         rem_reg;
    logic [mec_pkg::REM_W:0]           rem_inc;
    logic [mec_pkg::SX_W-1:0]          sx_reg;

    // hue divide
    logic [mec_pkg::NUM_W-1:0]         num_reg;
    logic [mec_pkg::NUM_W-1:0]         num_up;
    logic [mec_pkg::PQ_W-1:0]          t_prod;
    logic [mec_pkg::PQ_W-1:0]          c_prod;
    logic [mec_pkg::CH_W-1:0]          quo_reg;
    logic [mec_pkg::CH_W-1:0]          qceil_reg;

    // output
    logic [CNTX_W-1:0]                 cnt_x;
    logic [mec_pkg::CH_W-1:0]          t_val;
    logic [mec_pkg::CH_W-1:0]          q_val;
    logic [mec_pkg::CH_W-1:0]          cnt_out;
    logic [mec_pkg::CH_W-1:0]          r_col;
    logic [mec_pkg::CH_W-1:0]          g_col;
    logic [mec_pkg::CH_W-1:0]          b_col;
    logic [mec_pkg::CH_W-1:0]          cnt_out_reg;
    logic [mec_pkg::CH_W-1:0]          red_reg;
    logic [mec_pkg::CH_W-1:0]          green_reg;
    logic [mec_pkg::CH_W-1:0]          blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= mec_pkg::RST_PIXEL_STEP;
            cen_re_reg <= mec_pkg::RST_CENTER_REAL;
            cen_im_reg <= mec_pkg::RST_CENTER_IMAG;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mec_pkg::REG_PIXEL_STEP:  step_reg   <= cfg_data[mec_pkg::STEP_W-1:0];
                mec_pkg::REG_CENTER_REAL: cen_re_reg <= $signed(cfg_data);
                mec_pkg::REG_CENTER_IMAG: cen_im_reg <= $signed(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    // pixel offset times step, then add center and saturate
    assign dc     = $signed({{(mec_pkg::OFS_W - mec_pkg::PIX_W){1'b0}}, pixel_col})
                    - mec_pkg::HALF_COL;
    assign dr     = $signed({{(mec_pkg::OFS_W - mec_pkg::PIX_W){1'b0}}, pixel_row})
                    - mec_pkg::HALF_ROW;
    assign step_s = $signed({1'b0, step_reg});

    assign sum_re = {map_re_reg[mec_pkg::MAP_W-1], map_re_reg}
                    + {{(SUM_W - mec_pkg::C_W){cen_re_reg[mec_pkg::C_W-1]}}, cen_re_reg};
    assign sum_im = {map_im_reg[mec_pkg::MAP_W-1], map_im_reg}
                    + {{(SUM_W - mec_pkg::C_W){cen_im_reg[mec_pkg::C_W-1]}}, cen_im_reg};

    always_comb
    begin
        if (sum_re > SUM_MAX)
        begin
            sat_re = SUM_MAX[mec_pkg::C_W-1:0];
        end
        else if (sum_re < SUM_MIN)
        begin
            sat_re = SUM_MIN[mec_pkg::C_W-1:0];
        end
        else
        begin
            sat_re = sum_re[mec_pkg::C_W-1:0];
        end
        if (sum_im > SUM_MAX)
        begin
            sat_im = SUM_MAX[mec_pkg::C_W-1:0];
        end
        else if (sum_im < SUM_MIN)
        begin
            sat_im = SUM_MIN[mec_pkg::C_W-1:0];
        end
        else
        begin
            sat_im = sum_im[mec_pkg::C_W-1:0];
        end
    end

    // z update, only reached with both components within two
    assign mx      = x_reg[mec_pkg::MUL_W-1:0];
    assign my      = y_reg[mec_pkg::MUL_W-1:0];
    assign sum_sq  = {p_xx_reg[mec_pkg::PROD_W-1], p_xx_reg}
                     + {p_yy_reg[mec_pkg::PROD_W-1], p_yy_reg};
    assign diff_sq = {p_xx_reg[mec_pkg::PROD_W-1], p_xx_reg}
                     - {p_yy_reg[mec_pkg::PROD_W-1], p_yy_reg};
    assign x_new   = $signed(diff_sq[mec_pkg::FRAC + mec_pkg::Z_W - 1:mec_pkg::FRAC])
                     + {{(mec_pkg::Z_W - mec_pkg::C_W){cr_reg[mec_pkg::C_W-1]}}, cr_reg};
    assign y_new   = $signed(p_xy_reg[mec_pkg::FRAC + mec_pkg::Z_W - 2:mec_pkg::FRAC - 1])
                     + {{(mec_pkg::Z_W - mec_pkg::C_W){ci_reg[mec_pkg::C_W-1]}}, ci_reg};
    assign rem_inc = {1'b0, rem_reg} + (mec_pkg::REM_W + 1)'(mec_pkg::HUE_STEP);

    assign sts.esc_mag   = (x_reg > mec_pkg::TWO_POS) || (x_reg < mec_pkg::TWO_NEG)
                           || (y_reg > mec_pkg::TWO_POS) || (y_reg < mec_pkg::TWO_NEG);
    assign sts.esc_sum   = (sum_sq > mec_pkg::FOUR_Q56);
    assign sts.last_iter = (cnt_reg == mec_pkg::CNT_W'(mec_pkg::MAX_ITER - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            map_re_reg <= dc * step_s;
            map_im_reg <= dr * step_s;
        end
        if (cmd.map)
        begin
            cr_reg  <= sat_re;
            ci_reg  <= sat_im;
            x_reg   <= {{(mec_pkg::Z_W - mec_pkg::C_W){sat_re[mec_pkg::C_W-1]}}, sat_re};
            y_reg   <= {{(mec_pkg::Z_W - mec_pkg::C_W){sat_im[mec_pkg::C_W-1]}}, sat_im};
            cnt_reg <= '0;
            rem_reg <= '0;
            sx_reg  <= '0;
        end
        if (cmd.mul)
        begin
            p_xx_reg <= mx * mx;
            p_yy_reg <= my * my;
            p_xy_reg <= mx * my;
        end
        if (cmd.upd)
        begin
            x_reg   <= x_new;
            y_reg   <= y_new;
            cnt_reg <= cnt_reg + mec_pkg::CNT_W'(1);
            if (rem_inc >= (mec_pkg::REM_W + 1)'(mec_pkg::MAX_ITER))
            begin
                rem_reg <= mec_pkg::REM_W'(rem_inc - (mec_pkg::REM_W + 1)'(mec_pkg::MAX_ITER));
                sx_reg  <= sx_reg + mec_pkg::SX_W'(1);
            end
            else
            begin
                rem_reg <= rem_inc[mec_pkg::REM_W-1:0];
            end
        end
    end

    // floor and ceiling of 255 * rem over the iteration limit by reciprocal multiply
    assign num_up = num_reg + mec_pkg::NUM_W'(mec_pkg::MAX_ITER - 1);
    assign t_prod = {{mec_pkg::RECIP_W{1'b0}}, num_reg}
                    * {{mec_pkg::NUM_W{1'b0}}, mec_pkg::RECIP};
    assign c_prod = {{mec_pkg::RECIP_W{1'b0}}, num_up}
                    * {{mec_pkg::NUM_W{1'b0}}, mec_pkg::RECIP};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            num_reg <= {rem_reg, {mec_pkg::CH_W{1'b0}}} - mec_pkg::NUM_W'(rem_reg);
        end
        else if (cmd.div_step)
        begin
            quo_reg   <= t_prod[mec_pkg::RECIP_SH +: mec_pkg::CH_W];
            qceil_reg <= c_prod[mec_pkg::RECIP_SH +: mec_pkg::CH_W];
        end
    end

    // falling ramp is 255 minus the ceiling of the rising ramp
    assign t_val   = quo_reg;
    assign q_val   = mec_pkg::CHAN_MAX - qceil_reg;
    assign cnt_x   = CNTX_W'(cnt_reg);
    assign cnt_out = (cnt_x > CNTX_W'(mec_pkg::CHAN_MAX)) ? mec_pkg::CHAN_MAX
                                                          : cnt_x[mec_pkg::CH_W-1:0];

    always_comb
    begin
        r_col = '0;
        g_col = '0;
        b_col = '0;
        if (cnt_reg != mec_pkg::CNT_W'(mec_pkg::MAX_ITER))
        begin
            case (sx_reg)
                mec_pkg::SX_RED:
                begin
                    r_col = mec_pkg::CHAN_MAX;
                    g_col = t_val;
                end
                mec_pkg::SX_YELLOW:
                begin
                    r_col = q_val;
                    g_col = mec_pkg::CHAN_MAX;
                end
                mec_pkg::SX_GREEN:
                begin
                    g_col = mec_pkg::CHAN_MAX;
                    b_col = t_val;
                end
                mec_pkg::SX_CYAN:
                begin
                    g_col = q_val;
                    b_col = mec_pkg::CHAN_MAX;
                end
                mec_pkg::SX_BLUE:
                begin
                    r_col = t_val;
                    b_col = mec_pkg::CHAN_MAX;
                end
                default:
                begin
                    r_col = mec_pkg::CHAN_MAX;
                    b_col = q_val;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            cnt_out_reg <= cnt_out;
            red_reg     <= r_col;
            green_reg   <= g_col;
            blue_reg    <= b_col;
        end
    end

    assign escape_count = cnt_out_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;

endmodule

### hw/rtl/mandelbrot_escape_color.sv
// top level of the mandelbrot escape-time pixel colorer
//
// input channel: in_valid / in_stall carry one pixel word (pixel_col, pixel_row);
// a word is taken when in_valid is high and in_stall is low.
// output channel: out_valid / out_stall carry one result word (escape_count,
// red, green, blue) per pixel, held in an output register.
// config: cfg_we writes cfg_data into register cfg_index (0 pixel_step,
// 1 center_real, 2 center_imag); other indexes are ignored.
// one pixel is in work at a time; the escape loop shares three 31x31
// multipliers, and each iteration forms the products, then the update;
// the escape is found by the magnitude check before the products or by
// the squared compare before the update, and a pixel that never escapes
// stops after MAX_ITER updates. the color divide is a reciprocal multiply.
// a finished word waits in the output register while the next pixel is taken.
// when out_stall holds the output, the next result waits in the datapath and
// in_stall stays high until the output register frees up.
// reset clears the controller to idle, drops out_valid and restores the
// config registers to their default view.
module mandelbrot_escape_color (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mec_pkg::C_W-1:0]       cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mec_pkg::PIX_W-1:0]     pixel_col,
    input  logic [mec_pkg::PIX_W-1:0]     pixel_row,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mec_pkg::CH_W-1:0]      escape_count,
    output logic [mec_pkg::CH_W-1:0]      red,
    output logic [mec_pkg::CH_W-1:0]      green,
    output logic [mec_pkg::CH_W-1:0]      blue
);

    mec_pkg::mec_cmd_t cmd;
    mec_pkg::mec_sts_t sts;

    mec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mec_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_col    (pixel_col),
        .pixel_row    (pixel_row),
        .cmd          (cmd),
        .sts          (sts),
        .escape_count (escape_count),
        .red          (red),
        .green        (green),
        .blue         (blue)
    );

endmodule

### hw/rtl/mec_checker.sv
// port-level checker for the mandelbrot escape colorer, bound to the top level
module mec_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [mec_pkg::CH_W-1:0]      escape_count,
    input logic [mec_pkg::CH_W-1:0]      red,
    input logic [mec_pkg::CH_W-1:0]      green,
    input logic [mec_pkg::CH_W-1:0]      blue
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(escape_count) && $stable(red)
                                   && $stable(green) && $stable(blue))
        else $error("stalled result word changed");

    // one pixel at a time: busy right after a word is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a pixel is in work");

    // a point that never escapes is black
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mec_pkg::MAX_ITER <= 255)
        && (escape_count == mec_pkg::CH_W'(mec_pkg::MAX_ITER))
        |-> (red == '0) && (green == '0) && (blue == '0))
        else $error("non-escaping point not black");

    // any other colour has one channel at full value
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !((red == '0) && (green == '0) && (blue == '0))
        |-> (red == mec_pkg::CHAN_MAX) || (green == mec_pkg::CHAN_MAX)
            || (blue == mec_pkg::CHAN_MAX))
        else $error("hue colour without a full channel");

endmodule

bind mandelbrot_escape_color mec_checker u_mec_checker (.*);
